@@ hdl/feature_interval_intersect_table_core_assert.svh @@
// Assertion macros for the interval table core and its checker.
// Depends on nothing; included by the checker module.
`ifndef FEATURE_INTERVAL_INTERSECT_TABLE_CORE_ASSERT_SVH
`define FEATURE_INTERVAL_INTERSECT_TABLE_CORE_ASSERT_SVH
// Implication checked on every clock, disabled in reset.
`define FIIT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define FIIT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
// Delayed implication, disabled in reset.
`define FIIT_ASSERT_NXT2(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> ##1 (c)) \
        else $error("assertion failed");
`endif

@@ hdl/fiit_pkg.sv @@
// Package for the interval table core: sizes, action codes, float compare.
// Depends on nothing.
package fiit_pkg;
    localparam int FEATURE_SLOTS = 64;
    localparam int SLOT_W = (FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1;
    localparam int BOUND_W = 32;
    localparam int ACTION_W = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_APPLY = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

    typedef logic [BOUND_W-1:0] t_bound;
    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [5:0] feature_slot;
        t_bound bound_low;
        t_bound bound_high;
        logic apply_enable;
        logic last_of_candidate;
    } t_req;

    typedef struct packed {
        logic overlap_ok;
        logic verdict_done;
    } t_rsp;

    function automatic logic f_is_nan(input t_bound x);
        return x[30:0] > 31'h7F800000;
    endfunction

    function automatic t_bound f_key(input t_bound x);
        if (x[30:0] == 31'd0) return 32'h80000000;
        if (x[31]) return ~x;
        return x | 32'h80000000;
    endfunction

    function automatic logic f_less(input t_bound a, input t_bound b);
        if (f_is_nan(a) || f_is_nan(b)) return 1'b0;
        return f_key(a) < f_key(b);
    endfunction
endpackage

@@ hdl/fiit_stream_if.sv @@
// Valid/ready channel carrying one request or result payload.
// Depends on nothing.
interface fiit_stream_if #(parameter type t_payload = logic);
    logic valid;
    logic ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/fiit_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module fiit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ hdl/feature_interval_intersect_table_core.sv @@
// Top level of the interval table core: bound RAMs, active flags, verdict.
// Depends on fiit_pkg, fiit_stream_if and fiit_ram.
// A request is read from the bound RAMs in ST_IDLE, then compared and written
// back in ST_EXEC, which takes no new request and holds while the output register
// is full; a result waits in the output register while the next request is read.
module feature_interval_intersect_table_core (
    input  logic i_clk,
    input  logic i_rst_n,
    fiit_stream_if.sink   i_req,
    fiit_stream_if.source o_rsp
);
    import fiit_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    t_req r_req;
    logic [FEATURE_SLOTS-1:0] r_active, n_active;
    logic r_verdict, n_verdict;
    logic r_out_valid, n_out_valid;
    t_rsp r_out, n_out;

    t_slot w_slot, r_slot, w_raddr;
    t_bound w_lo_rd, w_hi_rd, w_lo_new, w_hi_new;
    logic w_accept, w_act, w_ok, w_we, w_out_free, w_fire;

    assign w_slot = SLOT_W'(32'(i_req.data.feature_slot) % FEATURE_SLOTS);
    assign w_raddr = (r_state == ST_IDLE) ? w_slot : r_slot;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept = i_req.valid && i_req.ready;
    assign w_fire = (r_state == ST_EXEC) && w_out_free;

    fiit_ram #(.WIDTH(BOUND_W), .DEPTH(FEATURE_SLOTS)) u_lo_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_slot), .i_wdata(w_lo_new),
        .i_raddr(w_raddr), .o_rdata(w_lo_rd));
    fiit_ram #(.WIDTH(BOUND_W), .DEPTH(FEATURE_SLOTS)) u_hi_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_slot), .i_wdata(w_hi_new),
        .i_raddr(w_raddr), .o_rdata(w_hi_rd));

    always_comb begin
        w_act = r_active[r_slot];
        w_lo_new = r_req.bound_low;
        w_hi_new = r_req.bound_high;
        if (w_act) begin
            w_lo_new = f_less(w_lo_rd, r_req.bound_low) ? r_req.bound_low : w_lo_rd;
            w_hi_new = f_less(r_req.bound_high, w_hi_rd) ? r_req.bound_high : w_hi_rd;
        end
        w_ok = f_less(w_lo_new, w_hi_new);
        w_we = w_fire && (r_req.action == ACT_APPLY) && r_req.apply_enable;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_EXEC;
            ST_EXEC: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out = r_out;
        n_active = r_active;
        n_verdict = r_verdict;
        if (w_fire) begin
            n_out_valid = 1'b1;
            n_out.overlap_ok = r_verdict;
            n_out.verdict_done = 1'b0;
            case (r_req.action)
                ACT_CLEAR: n_active = '0;
                ACT_CHECK: begin
                    n_out.overlap_ok = r_verdict && w_ok;
                    n_out.verdict_done = r_req.last_of_candidate;
                    n_verdict = r_req.last_of_candidate ? 1'b1 : (r_verdict && w_ok);
                end
                ACT_APPLY: if (r_req.apply_enable) n_active[r_slot] = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req.data;
            r_slot <= w_slot;
        end
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_active <= '0;
            r_verdict <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_active <= n_active;
            r_verdict <= n_verdict;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data = r_out;
endmodule

@@ hdl/fiit_checker.sv @@
// Port-level checker for the interval table core, bound to the top level.
// Depends on fiit_pkg, the assertion macro header and the core it is bound to.
`include "feature_interval_intersect_table_core_assert.svh"
module fiit_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input fiit_pkg::t_req i_req_data,
    input logic o_rsp_valid,
    input logic o_rsp_ready,
    input fiit_pkg::t_rsp o_rsp_data
);
    import fiit_pkg::*;

    logic w_req_acc;
    logic w_bad_bounds;

    assign w_req_acc = i_req_valid && i_req_ready;
    assign w_bad_bounds = (i_req_data.action == ACT_CHECK)
        && !f_is_nan(i_req_data.bound_low) && !f_is_nan(i_req_data.bound_high)
        && !f_less(i_req_data.bound_low, i_req_data.bound_high);

    `FIIT_ASSERT_NXT(a_rsp_after_req, i_clk, i_rst_n, w_req_acc, !i_req_ready)
    `FIIT_ASSERT_NXT(a_exec_fills_out, i_clk, i_rst_n, !i_req_ready && !o_rsp_valid, o_rsp_valid)
    `FIIT_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && !o_rsp_ready, o_rsp_valid && $stable(o_rsp_data))
    `FIIT_ASSERT_NXT2(a_bad_check, i_clk, i_rst_n, w_req_acc && w_bad_bounds && !o_rsp_valid, o_rsp_valid && !o_rsp_data.overlap_ok)
endmodule

bind feature_interval_intersect_table_core fiit_checker u_fiit_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid), .i_req_ready(i_req.ready), .i_req_data(i_req.data),
    .o_rsp_valid(o_rsp.valid), .o_rsp_ready(o_rsp.ready), .o_rsp_data(o_rsp.data));

@@ sim/feature_interval_intersect_table_checker.sv @@
// Checker for the interval table core: watches request and result channels,
// predicts each result and compares it. Depends on fiit_pkg.
module feature_interval_intersect_table_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_ready,
    input  fiit_pkg::t_req  i_req_data,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_ready,
    input  fiit_pkg::t_rsp  i_rsp_data,
    output int              o_errors,
    output int              o_pending
);
    import fiit_pkg::*;

    t_bound     lower_tbl [FEATURE_SLOTS];
    t_bound     upper_tbl [FEATURE_SLOTS];
    logic       slot_active [FEATURE_SLOTS];
    logic       verdict_run;
    t_rsp       verdict_q [$];

    assign o_pending = verdict_q.size();

    function automatic logic bound_lt(t_bound a, t_bound b);
        logic an;
        logic bn;
        logic [31:0] ka;
        logic [31:0] kb;
        an = (a & 32'h7FFFFFFF) > 32'h7F800000;
        bn = (b & 32'h7FFFFFFF) > 32'h7F800000;
        ka = (a[30:0] == 0) ? 32'h80000000 : (a[31] ? ~a : (a | 32'h80000000));
        kb = (b[30:0] == 0) ? 32'h80000000 : (b[31] ? ~b : (b | 32'h80000000));
        return !an && !bn && (ka < kb);
    endfunction

    task automatic report(string what, t_rsp got, t_rsp want);
        $display("mismatch %s: got ok=%0b done=%0b, want ok=%0b done=%0b",
            what, got.overlap_ok, got.verdict_done,
            want.overlap_ok, want.verdict_done);
        o_errors++;
    endtask

    task automatic predict_verdict(t_req r);
        t_rsp   res;
        int     s;
        logic   ok;
        t_bound lo;
        t_bound hi;
        s = r.feature_slot % FEATURE_SLOTS;
        res.overlap_ok = verdict_run;
        res.verdict_done = 1'b0;
        case (r.action)
            ACT_CLEAR: begin
                foreach (slot_active[i]) slot_active[i] = 1'b0;
            end
            ACT_CHECK: begin
                if (slot_active[s]) begin
                    lo = bound_lt(lower_tbl[s], r.bound_low) ? r.bound_low : lower_tbl[s];
                    hi = bound_lt(r.bound_high, upper_tbl[s]) ? r.bound_high : upper_tbl[s];
                    ok = bound_lt(lo, hi);
                end else begin
                    ok = bound_lt(r.bound_low, r.bound_high);
                end
                if (!ok) verdict_run = 1'b0;
                res.overlap_ok = verdict_run;
                if (r.last_of_candidate) begin
                    res.verdict_done = 1'b1;
                    verdict_run = 1'b1;
                end
            end
            ACT_APPLY: begin
                if (r.apply_enable) begin
                    if (slot_active[s]) begin
                        if (bound_lt(lower_tbl[s], r.bound_low)) lower_tbl[s] = r.bound_low;
                        if (bound_lt(r.bound_high, upper_tbl[s])) upper_tbl[s] = r.bound_high;
                    end else begin
                        lower_tbl[s] = r.bound_low;
                        upper_tbl[s] = r.bound_high;
                    end
                    slot_active[s] = 1'b1;
                end
            end
            default: ;
        endcase
        verdict_q = {verdict_q, res};
    endtask

    initial begin
        o_errors = 0;
        verdict_run = 1'b1;
        foreach (slot_active[i]) slot_active[i] = 1'b0;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (verdict_q.size() == 0) begin
                    report("unexpected", i_rsp_data, '0);
                end else begin
                    want = verdict_q.pop_front();
                    if (i_rsp_data.overlap_ok !== want.overlap_ok)
                        report("overlap_ok", i_rsp_data, want);
                    if (i_rsp_data.verdict_done !== want.verdict_done)
                        report("verdict_done", i_rsp_data, want);
                end
            end
            if (i_req_valid && i_req_ready) predict_verdict(i_req_data);
        end
    end
endmodule

@@ sim/testbench.sv @@
// Top of the interval table testbench: clock, reset, request stimulus,
// result stall and verdict. Depends on fiit_pkg, fiit_stream_if, the core and checker.
module testbench;
    import fiit_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   req_idle_pct;
    int   rsp_idle_pct;
    int   quiet_cycles;

    fiit_stream_if #(.t_payload(t_req)) req_if ();
    fiit_stream_if #(.t_payload(t_rsp)) rsp_if ();

    feature_interval_intersect_table_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    feature_interval_intersect_table_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_if.valid),
        .i_req_ready (req_if.ready),
        .i_req_data  (req_if.data),
        .i_rsp_valid (rsp_if.valid),
        .i_rsp_ready (rsp_if.ready),
        .i_rsp_data  (rsp_if.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        rsp_if.ready = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        req_idle_pct = 0;
        rsp_idle_pct = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) rsp_if.ready <= 1'b0;
        else rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_bound pick_bound();
        case ($urandom_range(9))
            0: return 32'h7F800000;
            1: return 32'hFF800000;
            2: return 32'h7FC00000 | $urandom_range(255);
            3: return 32'h80000000;
            4: return 32'h00000000;
            5: return $urandom();
            default: return {1'b0, 8'd127, 23'd0} + ($urandom_range(64) << 20)
                            ^ ($urandom_range(1) << 31);
        endcase
    endfunction

    task automatic send_request(t_req r);
        while ($urandom_range(99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        t_req r;
        logic [5:0] base;
        int kind;
        for (int n = 0; n < count; n++) begin
            base = 6'($urandom_range(7));
            kind = $urandom_range(99);
            r.feature_slot = base + 6'($urandom_range(3) == 0 ? $urandom_range(56) : 0);
            r.bound_low = pick_bound();
            r.bound_high = pick_bound();
            r.apply_enable = ($urandom_range(5) != 0);
            r.last_of_candidate = ($urandom_range(3) == 0);
            if (kind < 3) r.action = ACT_CLEAR;
            else if (kind < 5) r.action = ACT_NOP;
            else if (kind < 45) r.action = ACT_APPLY;
            else r.action = ACT_CHECK;
            send_request(r);
        end
    endtask

    initial begin
        t_req r;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        r = '0;
        r.action = ACT_CHECK; r.bound_low = 32'h00000000; r.bound_high = 32'h3F800000;
        send_request(r);
        r.bound_low = 32'h80000000; r.bound_high = 32'h00000000; r.last_of_candidate = 1'b1;
        send_request(r);
        r.bound_low = 32'hFF800000; r.bound_high = 32'h7F800000; r.last_of_candidate = 1'b0;
        send_request(r);
        r.bound_low = 32'h7FFFFFFF; r.last_of_candidate = 1'b1;
        send_request(r);
        r.action = ACT_APPLY; r.feature_slot = 6'h3F; r.apply_enable = 1'b1;
        r.bound_low = 32'hBF800000; r.bound_high = 32'h40000000;
        send_request(r);
        r.bound_low = 32'hFFC00000; r.bound_high = 32'h3F800000;
        send_request(r);
        r.action = ACT_CHECK; r.bound_low = 32'h3F000000; r.bound_high = 32'hFFFFFFFF;
        send_request(r);
        r.bound_low = 32'h3F800000; r.bound_high = 32'h7F800000;
        send_request(r);
        r.action = ACT_APPLY; r.apply_enable = 1'b0; r.feature_slot = '0;
        send_request(r);
        r.action = ACT_NOP; r.bound_low = '1; r.bound_high = '1; r.last_of_candidate = 1'b1;
        send_request(r);
        r.action = ACT_CLEAR;
        send_request(r);
        r.action = ACT_CHECK; r.feature_slot = 6'h3F;
        r.bound_low = 32'h3F800000; r.bound_high = 32'h40000000;
        send_request(r);

        req_idle_pct = 12; rsp_idle_pct = 58;
        send_random(400);
        req_idle_pct = 58; rsp_idle_pct = 12;
        send_random(400);
        req_idle_pct = 0; rsp_idle_pct = 0;
        send_random(450);
        req_if.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hdl
hdl/fiit_pkg.sv
hdl/fiit_stream_if.sv
hdl/fiit_ram.sv
hdl/feature_interval_intersect_table_core.sv
hdl/fiit_checker.sv
sim/feature_interval_intersect_table_checker.sv
sim/testbench.sv
